/* design/sq16_pkg.sv */
// ----------------------------------------------------------------------------
// sq16_pkg: shared types and constants of the saturating Q0.16 ALU
// Opcode encoding, the per-stage transaction record and the sizing of the
// pipelined fractional divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sq16_pkg;

  localparam int unsigned QW = 16;
  localparam logic [QW-1:0] Q_MAX = 16'hFFFF;

  // The divider resolves this many quotient bits in each pipeline stage.
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES = QW / DIV_BITS_PER_STAGE;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_XOR = 3'd4,
    OP_NOT = 3'd5,
    OP_ABS = 3'd6
  } op_t;

  // One transaction as it travels down the pipeline.
  typedef struct packed {
    op_t           op;
    logic [QW-1:0] divisor;
    logic [QW-1:0] rem;
    logic [QW-1:0] quo;
    logic [QW-1:0] res;     // finished result, or first soft-xor product
    logic [QW-1:0] xa;      // second soft-xor product
    logic          dz;
    logic          sat;     // quotient overflows 16 bits
  } sq16_item_t;

endpackage

`default_nettype wire

/* design/sq16_if.sv */
// ----------------------------------------------------------------------------
// sq16 channel interfaces
// Valid/ready channels for the request and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface sq16_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] operand_a;
  logic [15:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface sq16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_value;
  logic        divide_by_zero;

  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

`default_nettype wire

/* design/sq16_front.sv */
// ----------------------------------------------------------------------------
// sq16_front: first pipeline stage
// Decodes the opcode, runs both multipliers and finishes the simple
// operations; seeds the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sq16_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire logic [2:0]          up_op,
  input  wire logic [15:0]         up_a,
  input  wire logic [15:0]         up_b,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output sq16_pkg::sq16_item_t     dn_item
);
  import sq16_pkg::*;

  logic       valid_r;
  sq16_item_t item_r, item_nxt;
  logic       en;
  op_t        op;
  logic [QW-1:0]   na, nb, mb;
  logic [2*QW-1:0] prod1, prod2;
  logic [QW:0]     sum;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  always_comb begin
    op    = op_t'(up_op);
    na    = ~up_a;
    nb    = ~up_b;
    mb    = (op == OP_XOR) ? nb : up_b;
    prod1 = up_a * mb;
    prod2 = up_b * na;
    sum   = {1'b0, up_a} + {1'b0, up_b};

    item_nxt         = '0;
    item_nxt.op      = op;
    item_nxt.divisor = up_b;
    item_nxt.rem     = up_a;
    item_nxt.xa      = prod2[2*QW-1:QW];
    item_nxt.dz      = (op == OP_DIV) && (up_b == '0);
    item_nxt.sat     = (up_a >= up_b);
    case (op)
      OP_ADD:  item_nxt.res = sum[QW] ? Q_MAX : sum[QW-1:0];
      OP_SUB:  item_nxt.res = (up_a >= up_b) ? up_a - up_b : '0;
      OP_MUL:  item_nxt.res = prod1[2*QW-1:QW];
      OP_XOR:  item_nxt.res = prod1[2*QW-1:QW];
      OP_NOT:  item_nxt.res = na;
      OP_ABS:  item_nxt.res = (up_b > up_a) ? up_b - up_a : up_a - up_b;
      default: item_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/sq16_div_stage.sv */
// ----------------------------------------------------------------------------
// sq16_div_stage: one stage of the restoring fractional divider
// Resolves DIV_BITS_PER_STAGE quotient bits of (a << 16) / b and passes the
// rest of the transaction through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module sq16_div_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire sq16_pkg::sq16_item_t up_item,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output sq16_pkg::sq16_item_t     dn_item
);
  import sq16_pkg::*;

  logic       valid_r;
  sq16_item_t item_r, item_nxt;
  logic       en;
  logic [QW:0] shifted;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // The dividend's low half is all zeros, so each step shifts in a zero.
  // While a < b the remainder stays below the divisor and fits 16 bits.
  always_comb begin
    item_nxt = up_item;
    shifted  = '0;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      shifted = {item_nxt.rem, 1'b0};
      if (shifted >= {1'b0, item_nxt.divisor}) begin
        shifted      = shifted - {1'b0, item_nxt.divisor};
        item_nxt.quo = {item_nxt.quo[QW-2:0], 1'b1};
      end else begin
        item_nxt.quo = {item_nxt.quo[QW-2:0], 1'b0};
      end
      item_nxt.rem = shifted[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/sq16_resolve.sv */
// ----------------------------------------------------------------------------
// sq16_resolve: last pipeline stage and output register
// Saturates the quotient, finishes the soft-xor sum and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sq16_resolve (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire sq16_pkg::sq16_item_t up_item,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output logic [15:0]              dn_value,
  output logic                     dn_dz
);
  import sq16_pkg::*;

  logic          valid_r;
  logic [QW-1:0] value_r, value_nxt;
  logic          dz_r;
  logic          en;
  logic [QW:0]   sum;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid_r;
  assign dn_value = value_r;
  assign dn_dz    = dz_r;

  always_comb begin
    sum = {1'b0, up_item.res} + {1'b0, up_item.xa};
    case (up_item.op)
      OP_DIV:  value_nxt = (up_item.dz || up_item.sat) ? Q_MAX : up_item.quo;
      OP_XOR:  value_nxt = sum[QW] ? Q_MAX : sum[QW-1:0];
      default: value_nxt = up_item.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      value_r <= value_nxt;
      dz_r    <= up_item.dz;
    end
  end

endmodule

`default_nettype wire

/* design/saturating_q16_soft_logic_alu.sv */
// ----------------------------------------------------------------------------
// saturating_q16_soft_logic_alu: pipelined unsigned Q0.16 soft-logic ALU
// Saturating add/sub/mul/div, soft xor, soft not and absolute difference.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction (req_type, operand_a,
//   operand_b); out_ch returns one transaction per request, in order, with
//   result_value and divide_by_zero.
//   The pipeline has six register stages: operand decode and the two 16x16
//   multipliers, four divider stages of four quotient bits each, and the
//   output register. Throughput is one transaction per cycle while out_ch
//   is not stalled; the divider stage depth sets the latency, not the
//   rate.
//   Each stage holds its transaction while the stage after it is full and
//   stalled, so a stall on out_ch backs up stage by stage; empty stages
//   still fill, and in_ch.ready drops only when every stage is occupied.
//   A divide by zero returns 0xFFFF with divide_by_zero set.
//   Synchronous reset empties the pipeline; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module saturating_q16_soft_logic_alu (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sq16_in_if.sink    in_ch,
  sq16_out_if.source out_ch
);
  import sq16_pkg::*;

  logic       stg_valid [0:DIV_STAGES];
  logic       stg_ready [0:DIV_STAGES];
  sq16_item_t stg_item  [0:DIV_STAGES];

  sq16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_op    (in_ch.req_type),
    .up_a     (in_ch.operand_a),
    .up_b     (in_ch.operand_b),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_item  (stg_item[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    sq16_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_item  (stg_item[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_item  (stg_item[g+1])
    );
  end

  sq16_resolve u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[DIV_STAGES]),
    .up_ready (stg_ready[DIV_STAGES]),
    .up_item  (stg_item[DIV_STAGES]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_value (out_ch.result_value),
    .dn_dz    (out_ch.divide_by_zero)
  );

  // A flagged division always reports the saturated value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> out_ch.result_value == Q_MAX)
    else $error("divide_by_zero set without saturated result");

  // The flag is only ever raised for a division.
  assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[DIV_STAGES] && stg_item[DIV_STAGES].dz |->
      stg_item[DIV_STAGES].op == OP_DIV && stg_item[DIV_STAGES].divisor == '0)
    else $error("divide_by_zero carried by a non-division transaction");

  // Reset empties the pipeline.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

/* tb/sq16_result_check.sv */
// ----------------------------------------------------------------------------
// sq16_result_check: result predictor and comparator for the Q0.16 ALU
// Watches both channels. For every accepted request it computes the expected
// result and divide-by-zero flag, and checks every accepted result against
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sq16_result_check (
  input  logic        clk,
  input  logic        rst_n,
  sq16_in_if          in_ch,
  sq16_out_if         out_ch,
  output int unsigned error_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import sq16_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic        dz;
  } q16_result_t;

  q16_result_t predicted_results[$];

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? Q_MAX : s[15:0];
  endfunction

  function automatic logic [15:0] prod_high(logic [15:0] a, logic [15:0] b);
    logic [31:0] p;
    p = {16'd0, a} * {16'd0, b};
    return p[31:16];
  endfunction

  function automatic q16_result_t q16_alu_op(logic [2:0] op, logic [15:0] a,
                                             logic [15:0] b);
    q16_result_t r;
    logic [31:0] quo;
    r = '0;
    case (op)
      OP_ADD: r.value = sat_sum(a, b);
      OP_SUB: r.value = (a >= b) ? a - b : 16'd0;
      OP_MUL: r.value = prod_high(a, b);
      OP_DIV: begin
        if (b == 16'd0) begin
          r.value = Q_MAX;
          r.dz    = 1'b1;
        end else begin
          quo     = {a, 16'd0} / {16'd0, b};
          r.value = (quo > {16'd0, Q_MAX}) ? Q_MAX : quo[15:0];
        end
      end
      OP_XOR: r.value = sat_sum(prod_high(a, Q_MAX - b), prod_high(b, Q_MAX - a));
      OP_NOT: r.value = Q_MAX - a;
      OP_ABS: r.value = (b > a) ? b - a : a - b;
      default: r.value = 16'd0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    q16_result_t exp_r;
    if (!rst_n) begin
      error_count = 0;
      predicted_results.delete();
    end else begin
      // Results are checked before new requests are queued, so a result can
      // never be matched against a prediction made in the same cycle.
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %h dz %b with no request outstanding",
                                    out_ch.result_value, out_ch.divide_by_zero));
        end else begin
          exp_r = predicted_results.pop_front();
          if (out_ch.result_value !== exp_r.value)
            report_mismatch($sformatf("result_value got %h expected %h",
                                      out_ch.result_value, exp_r.value));
          if (out_ch.divide_by_zero !== exp_r.dz)
            report_mismatch($sformatf("divide_by_zero got %b expected %b",
                                      out_ch.divide_by_zero, exp_r.dz));
        end
      end
      if (in_ch.valid && in_ch.ready)
        predicted_results.push_back(q16_alu_op(in_ch.req_type, in_ch.operand_a,
                                               in_ch.operand_b));
    end
    pending_count = predicted_results.size();
  end

endmodule

/* tb/saturating_q16_soft_logic_alu_test.sv */
// ----------------------------------------------------------------------------
// saturating_q16_soft_logic_alu_test: top level of the Q0.16 ALU testbench
// Drives a directed set of corner cases and then random requests through
// phases of sender idling and receiver stalls; the result checker beside the
// block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module saturating_q16_soft_logic_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sq16_pkg::*;

  localparam logic [2:0]  OP_UNUSED      = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 120;
  localparam int unsigned IDLE_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES   = 12;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned error_count;
  int unsigned pending_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned idle_cycles;

  int unsigned phase_send[4] = '{0, 80, 0, 33};
  int unsigned phase_recv[4] = '{0, 0, 80, 33};

  sq16_in_if  in_ch ();
  sq16_out_if out_ch ();

  saturating_q16_soft_logic_alu i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sq16_result_check i_result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycles without any transaction on either channel end the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Operands lean toward the saturation edges and small values.
  function automatic logic [15:0] rand_operand();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return Q_MAX;
      2: return 16'($urandom_range(15));
      3: return 16'($urandom_range(16'hFFFF, 16'hFFF0));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic [2:0] op, input logic [15:0] a,
                          input logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    logic [2:0]  op;
    logic [15:0] a;
    logic [15:0] b;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = OP_ADD;
    in_ch.operand_a = 16'd0;
    in_ch.operand_b = 16'd0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Corner cases, sent back to back.
    send_req(OP_ADD, Q_MAX, Q_MAX);
    send_req(OP_ADD, 16'h0000, 16'h0000);
    send_req(OP_ADD, 16'h8000, 16'h7FFF);
    send_req(OP_SUB, 16'h0000, Q_MAX);
    send_req(OP_SUB, Q_MAX, 16'h0000);
    send_req(OP_SUB, 16'h1234, 16'h1234);
    send_req(OP_MUL, Q_MAX, Q_MAX);
    send_req(OP_MUL, 16'h0000, Q_MAX);
    send_req(OP_MUL, 16'h8000, 16'h8000);
    send_req(OP_DIV, 16'h0000, 16'h0000);
    send_req(OP_DIV, Q_MAX, 16'h0000);
    send_req(OP_DIV, 16'h0001, Q_MAX);
    send_req(OP_DIV, Q_MAX, Q_MAX);
    send_req(OP_DIV, 16'h0001, 16'h0002);
    send_req(OP_DIV, 16'h5555, 16'hAAAA);
    send_req(OP_XOR, 16'h0000, 16'h0000);
    send_req(OP_XOR, Q_MAX, Q_MAX);
    send_req(OP_XOR, 16'h0000, Q_MAX);
    send_req(OP_XOR, 16'h8000, 16'h8000);
    send_req(OP_NOT, 16'h0000, Q_MAX);
    send_req(OP_NOT, Q_MAX, 16'h5A5A);
    send_req(OP_ABS, 16'h0000, Q_MAX);
    send_req(OP_ABS, Q_MAX, 16'h0000);
    send_req(OP_UNUSED, Q_MAX, Q_MAX);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = phase_send[phase];
      recv_stall_pct = phase_recv[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        op = 3'($urandom_range(7));
        a  = rand_operand();
        b  = rand_operand();
        send_req(op, a, b);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
